@@ rtl/smef_pkg.sv @@
// ============================================================================
// smef_pkg - shared types and constants of the stream mux escape framer
// Byte codes, frame size, and the run and state records that pass between
// the encoder and the top level.
// ============================================================================
`default_nettype none

package smef_pkg;

    // Frame size in bytes (8..65536) and the width of the fill counter
    localparam int unsigned FRAME_BYTES = 4096;
    localparam int unsigned FILL_W      = 17;

    // Most output bytes one input byte can produce, and the count width
    localparam int unsigned MAX_RUN = 6;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned IDX_W   = 3;

    // Frame limit at one bit over the fill width, for the end-of-frame compare
    localparam logic [FILL_W:0] FRAME_LIMIT = (FILL_W + 1)'(FRAME_BYTES);

    // Byte codes on the uplink
    localparam logic [7:0] ESC_BYTE = 8'hfe;
    localparam logic [7:0] END_BYTE = 8'h00;
    localparam logic [7:0] CTL_BYTE = 8'hfd;

    // Framer state kept between input bytes
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [7:0]        stream;
        logic              active;
    } t_state;

    // Output run produced by one input byte
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
    } t_plan;

endpackage

`default_nettype wire

@@ rtl/smef_encode.sv @@
// ============================================================================
// smef_encode - per-byte framing logic
// Builds the run of up to six uplink bytes for one input byte (header,
// frame-restart header, escape, data, trailer) and the next framer state.
// ============================================================================
`default_nettype none

module smef_encode (
    input  wire logic [7:0]     i_stream_id,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_first_of_batch,
    input  wire logic           i_last_of_batch,
    input  wire smef_pkg::t_state i_state,
    output smef_pkg::t_plan     o_plan,
    output smef_pkg::t_state    o_state
);

    logic                               id_ok;
    logic [smef_pkg::FILL_W-1:0]        fill;
    logic [smef_pkg::CNT_W-1:0]         k;
    logic                               active;
    logic [7:0]                         stream;
    logic [smef_pkg::MAX_RUN-1:0][7:0]  bytes;

    // Stream id 0 and the two control codes are not usable ids
    assign id_ok = (i_stream_id != 8'h00) && (i_stream_id != smef_pkg::ESC_BYTE) &&
                   (i_stream_id != smef_pkg::CTL_BYTE);

    // Assemble the run in output order
    always_comb begin
        bytes  = '0;
        k      = '0;
        active = i_first_of_batch ? id_ok : i_state.active;
        stream = i_first_of_batch ? i_stream_id : i_state.stream;
        fill   = i_first_of_batch ? '0 : i_state.fill;

        // batch header
        if (i_first_of_batch && id_ok) begin
            bytes[k[smef_pkg::IDX_W-1:0]] = smef_pkg::ESC_BYTE;
            k = k + smef_pkg::CNT_W'(1);
            bytes[k[smef_pkg::IDX_W-1:0]] = i_stream_id;
            k = k + smef_pkg::CNT_W'(1);
            fill = fill + smef_pkg::FILL_W'(2);
        end

        if (active) begin
            // frame full: restart the count and repeat the header
            if (({1'b0, fill} + (smef_pkg::FILL_W + 1)'(4)) >= smef_pkg::FRAME_LIMIT) begin
                bytes[k[smef_pkg::IDX_W-1:0]] = smef_pkg::ESC_BYTE;
                k = k + smef_pkg::CNT_W'(1);
                bytes[k[smef_pkg::IDX_W-1:0]] = stream;
                k = k + smef_pkg::CNT_W'(1);
                fill = smef_pkg::FILL_W'(2);
            end
            // escape doubling
            if (i_data_byte == smef_pkg::ESC_BYTE) begin
                bytes[k[smef_pkg::IDX_W-1:0]] = smef_pkg::ESC_BYTE;
                k = k + smef_pkg::CNT_W'(1);
                fill = fill + smef_pkg::FILL_W'(1);
            end
            bytes[k[smef_pkg::IDX_W-1:0]] = i_data_byte;
            k = k + smef_pkg::CNT_W'(1);
            fill = fill + smef_pkg::FILL_W'(1);
            // trailer closes the batch
            if (i_last_of_batch) begin
                bytes[k[smef_pkg::IDX_W-1:0]] = smef_pkg::ESC_BYTE;
                k = k + smef_pkg::CNT_W'(1);
                bytes[k[smef_pkg::IDX_W-1:0]] = smef_pkg::END_BYTE;
                k = k + smef_pkg::CNT_W'(1);
                active = 1'b0;
                fill   = '0;
            end
        end
    end

    assign o_plan.bytes   = bytes;
    assign o_plan.cnt     = k;
    assign o_state.fill   = fill;
    assign o_state.stream = stream;
    assign o_state.active = active;

endmodule

`default_nettype wire

@@ rtl/stream_mux_escape_framer_unit.sv @@
// ============================================================================
// stream_mux_escape_framer_unit - escape-stuffing stream mux framer
// Frames batch payload bytes with a stream header, byte stuffing of 0xFE,
// periodic header repeats and an end trailer, one byte per unstalled cycle.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  input   | in        | i_valid / o_stall  | stream id, data byte, first, last
//  output  | out       | o_valid / i_stall  | out byte, last of run
//
//  An input byte yields 0 to 6 uplink bytes; the output sends one per cycle
//  while not stalled. The run is held in a plan register and drained into
//  the output register; the next input is taken in the cycle the last byte
//  of a run leaves the plan register.
//  Bytes that produce no output are taken every cycle while the plan is empty.
//  Reset (synchronous, active low) clears framer state, plan and output valid.
//
`default_nettype none

module stream_mux_escape_framer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_stream_id,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_of_batch,
    input  wire logic       i_last_of_batch,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);

    smef_pkg::t_state               r_state;
    smef_pkg::t_state               n_state;
    smef_pkg::t_plan                enc_plan;
    smef_pkg::t_plan                r_plan;
    logic [smef_pkg::IDX_W-1:0]     r_idx;
    logic                           r_busy;
    logic                           r_ovalid;
    logic [7:0]                     r_obyte;
    logic                           r_olast;
    logic                           out_free;
    logic                           move;
    logic                           move_last;
    logic                           accept;

    // Per-byte framing
    smef_encode u_encode (
        .i_stream_id      (i_stream_id),
        .i_data_byte      (i_data_byte),
        .i_first_of_batch (i_first_of_batch),
        .i_last_of_batch  (i_last_of_batch),
        .i_state          (r_state),
        .o_plan           (enc_plan),
        .o_state          (n_state)
    );

    // Handshake control
    assign out_free  = !r_ovalid || !i_stall;
    assign move      = r_busy && out_free;
    assign move_last = move && (smef_pkg::CNT_W'(r_idx) == (r_plan.cnt - smef_pkg::CNT_W'(1)));
    assign o_stall   = r_busy && !move_last;
    assign accept    = i_valid && !o_stall;

    // Framer state advances on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Plan register: holds one run while it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (accept && (enc_plan.cnt != '0)) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (move_last) begin
            r_busy <= 1'b0;
        end else if (move) begin
            r_idx <= r_idx + smef_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (enc_plan.cnt != '0)) begin
            r_plan <= enc_plan;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (move) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_obyte <= r_plan.bytes[r_idx];
            r_olast <= move_last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_last_of_run = r_olast;

    // Checks
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_plan.cnt != '0) && (smef_pkg::CNT_W'(r_idx) < r_plan.cnt)))
        else $error("plan index out of run");

    a_idle_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.active |-> (r_state.fill == '0))
        else $error("fill not cleared outside a batch");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.active |-> ({1'b0, r_state.fill} < smef_pkg::FRAME_LIMIT))
        else $error("frame fill beyond frame size");

    a_drain_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_ovalid && (r_olast == !r_busy || r_idx == '0)))
        else $error("output register missed a run byte");

endmodule

`default_nettype wire
